/* rtl/ska_pkg.sv */
package ska_pkg;

   localparam int CAPACITY    = 16;
   localparam int KEY_WIDTH   = 32;
   localparam int CNT_W       = $clog2(CAPACITY + 1);

   // Fixed field widths of the two channels
   localparam int CMD_W       = 3;
   localparam int KEY_FIELD_W = 32;
   localparam int POS_W       = 5;
   localparam int FIDX_W      = 5;
   localparam int FCNT_W      = 5;
   localparam int STAT_W      = 2;
   localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_ORDERED_INSERT = 3'd0,
      CMD_INSERT_AT      = 3'd1,
      CMD_DELETE_AT      = 3'd2,
      CMD_FIND           = 3'd3,
      CMD_APPEND         = 3'd4,
      CMD_DETACH_LAST    = 3'd5
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   typedef enum logic [1:0] {
      MODE_HOLD,
      MODE_PLACE,
      MODE_TAKE
   } cell_mode_type;

   typedef struct packed {
      logic [CMD_W-1:0]       command;
      logic [KEY_FIELD_W-1:0] key;
      logic [POS_W-1:0]       position;
   } req_type;

   typedef struct packed {
      logic [FIDX_W-1:0]      found_index;
      logic [KEY_FIELD_W-1:0] entry_value;
      logic [FCNT_W-1:0]      entry_count;
      logic [STAT_W-1:0]      status;
   } rsp_type;

   // Broadcast from the controller to every cell
   typedef struct packed {
      logic                 capture;
      logic [KEY_WIDTH-1:0] cmp_key;
      cell_mode_type        mode;
      logic [CNT_W-1:0]     target;
      logic [KEY_WIDTH-1:0] load_key;
      logic [CNT_W-1:0]     count;
   } cell_ctl_type;

   // What each cell reports back
   typedef struct packed {
      logic                 below;
      logic                 first;
      logic [KEY_WIDTH-1:0] target_value;
   } cell_out_type;

   // Row summary handed to the controller
   typedef struct packed {
      logic                 hit;
      logic [CNT_W-1:0]     index;
      logic [KEY_WIDTH-1:0] value;
   } loc_type;

endpackage

/* rtl/ska_cell.sv */
module ska_cell import ska_pkg::*; (
   input  logic                 clock,
   input  logic [CNT_W-1:0]     cell_index,
   input  cell_ctl_type         ctl,
   input  logic                 left_below,
   input  logic [KEY_WIDTH-1:0] left_entry,
   input  logic [KEY_WIDTH-1:0] right_entry,
   output logic [KEY_WIDTH-1:0] entry,
   output cell_out_type         stat
);

   logic [KEY_WIDTH-1:0] entry_ff, entry_in;
   logic                 lt_ff, lt_in;
   logic                 occupied;
   logic                 below_here;

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.mode)
         MODE_HOLD: begin
            entry_in = entry_ff;
         end
         MODE_PLACE: begin
            if (cell_index > ctl.target) begin
               entry_in = left_entry;
            end else if (cell_index == ctl.target) begin
               entry_in = ctl.load_key;
            end
         end
         MODE_TAKE: begin
            if (cell_index >= ctl.target) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // Compare against the key of the incoming transfer
   assign lt_in      = ctl.capture ? (entry_ff < ctl.cmp_key) : lt_ff;
   assign occupied   = cell_index < ctl.count;
   assign below_here = lt_ff & occupied;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      lt_ff    <= lt_in;
   end

   // left_below means every cell to the left is below the key; pass it on only
   // while this cell is below too, so the first flag stays unique in an unsorted row
   assign entry             = entry_ff;
   assign stat.below        = below_here & left_below;
   assign stat.first        = ~below_here & left_below & occupied;
   assign stat.target_value = (cell_index == ctl.target) ? entry_ff : '0;

endmodule

/* rtl/ska_ctrl.sv */
module ska_ctrl import ska_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data,
   input  loc_type      loc,
   output cell_ctl_type ctl
);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 accept, out_free, commit, full;
   logic [CMP_W-1:0]     pos_ext, cnt_ext;
   logic [CNT_W-1:0]     locate_idx, idx, target, count_next;
   logic [KEY_WIDTH-1:0] value;
   status_type           status;
   cell_mode_type        mode;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign commit    = (state_ff == S_EXEC) & out_free;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_EXEC;
         S_EXEC: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Command decode and outputs
   always_comb begin
      full       = (count_ff == CNT_W'(CAPACITY));
      pos_ext    = CMP_W'(pos_ff);
      cnt_ext    = CMP_W'(count_ff);
      locate_idx = loc.hit ? loc.index : count_ff;
      mode       = MODE_HOLD;
      target     = '0;
      idx        = '0;
      value      = '0;
      status     = ST_OK;
      count_next = count_ff;
      unique case (cmd_ff)
         CMD_ORDERED_INSERT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               idx        = locate_idx;
               target     = locate_idx;
               mode       = MODE_PLACE;
               count_next = count_ff + 1'b1;
            end
         end
         CMD_INSERT_AT: begin
            if (full) begin
               status = ST_FULL;
            end else if (pos_ext > cnt_ext) begin
               status = ST_RANGE;
            end else begin
               idx        = CNT_W'(pos_ff);
               target     = CNT_W'(pos_ff);
               mode       = MODE_PLACE;
               count_next = count_ff + 1'b1;
            end
         end
         CMD_DELETE_AT: begin
            if (pos_ext >= cnt_ext) begin
               status = ST_RANGE;
            end else begin
               idx        = CNT_W'(pos_ff);
               target     = CNT_W'(pos_ff);
               value      = loc.value;
               mode       = MODE_TAKE;
               count_next = count_ff - 1'b1;
            end
         end
         CMD_FIND: begin
            idx = locate_idx;
         end
         CMD_APPEND: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               idx        = count_ff;
               target     = count_ff;
               mode       = MODE_PLACE;
               count_next = count_ff + 1'b1;
            end
         end
         CMD_DETACH_LAST: begin
            if (count_ff == '0) begin
               status = ST_RANGE;
            end else begin
               idx        = count_ff - 1'b1;
               target     = count_ff - 1'b1;
               value      = loc.value;
               mode       = MODE_TAKE;
               count_next = count_ff - 1'b1;
            end
         end
         default: begin
            status = ST_RANGE;
         end
      endcase

      ctl.capture  = accept;
      ctl.cmp_key  = KEY_WIDTH'(req_data.key);
      ctl.mode     = commit ? mode : MODE_HOLD;
      ctl.target   = target;
      ctl.load_key = key_ff;
      ctl.count    = count_ff;

      count_in     = commit ? count_next : count_ff;
      cmd_in       = accept ? req_data.command : cmd_ff;
      key_in       = accept ? KEY_WIDTH'(req_data.key) : key_ff;
      pos_in       = accept ? req_data.position : pos_ff;

      rsp_valid_in = commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = rsp_data_ff;
      if (commit) begin
         rsp_data_in.found_index = FIDX_W'(idx);
         rsp_data_in.entry_value = KEY_FIELD_W'(value);
         rsp_data_in.entry_count = FCNT_W'(count_next);
         rsp_data_in.status      = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EXEC)
      else $error("accepted transfer not executed");

   a_error_no_change: assert property (@(posedge clock) disable iff (reset)
      (commit && status != ST_OK) |=> count_ff == $past(count_ff))
      else $error("failed command changed the count");

   a_place_grows: assert property (@(posedge clock) disable iff (reset)
      (commit && mode == MODE_PLACE) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the count");

   a_commit_response: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("executed command gave no response");

endmodule

/* rtl/sorted_key_array_engine_top.sv */
// Sorted key array engine: one node's worth of sorted keys plus an entry count.
// Request channel (req_valid/req_ready/req_data) carries a command, key and
// position; the response channel (rsp_valid/rsp_ready/rsp_data) returns one
// result per request: index, removed entry, entry count after the command
// and a status (ok, full, out of range).
// Flow: a request transfer is followed by an execute state, and the result
// is registered, so rsp_valid rises in the cycle after the execute state commits.
// A request is taken only in the idle state, so each one passes the compare
// step (every cell compares its entry with the key) and the shift step (the
// cells from the target on load from a neighbor) of the cell row before the next.
// A finished result waits in the response register; the next request is
// still taken, and its execute cycle holds until the register frees up.
// Reset clears the entry count, the state and the response valid; entry
// contents are not cleared, and only entries below the count are ever read.
module sorted_key_array_engine_top import ska_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cell_ctl_type         ctl;
   cell_out_type         stat  [CAPACITY];
   logic [KEY_WIDTH-1:0] entry [CAPACITY];
   logic [CAPACITY-1:0]  first_vec;
   loc_type              loc;

   ska_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .loc       (loc),
      .ctl       (ctl)
   );

   // Row of cells; cell i shifts from i-1 on insert and from i+1 on delete
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                 left_below;
      logic [KEY_WIDTH-1:0] left_entry;
      logic [KEY_WIDTH-1:0] right_entry;

      if (i == 0) begin : g_head
         assign left_below = 1'b1;
         assign left_entry = '0;
      end else begin : g_body
         assign left_below = stat[i-1].below;
         assign left_entry = entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = entry[i];
      end else begin : g_inner
         assign right_entry = entry[i+1];
      end

      ska_cell u_cell (
         .clock       (clock),
         .cell_index  (CNT_W'(i)),
         .ctl         (ctl),
         .left_below  (left_below),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entry[i]),
         .stat        (stat[i])
      );

      assign first_vec[i] = stat[i].first;
   end

   // Merge the one-hot first flag and the selected entry across the row
   always_comb begin
      loc.hit   = |first_vec;
      loc.index = '0;
      loc.value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first_vec[i]) begin
            loc.index = loc.index | CNT_W'(i);
         end
         loc.value = loc.value | stat[i].target_value;
      end
   end

   // Compare flags are fresh only while a command executes
   a_first_onehot: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> $onehot0(first_vec))
      else $error("more than one insertion point in the row");

endmodule
